// ----- rtl/eld_pkg.sv -----
package eld_pkg;

    localparam int LOG_WORDS_DEFAULT = 4096;
    localparam int POS_W             = 12;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [15:0] BEGIN_WORD = 16'hFFFC;
    localparam logic [12:0] OPC_MARK   = 13'h1FFF;

    localparam logic [2:0] OP_FULLTIME = 3'd1;
    localparam logic [2:0] OP_CONFIG   = 3'd2;
    localparam logic [2:0] OP_DONE     = 3'd3;
    localparam logic [2:0] OP_BEGIN    = 3'd4;
    localparam logic [2:0] OP_SETTIME  = 3'd5;

    localparam logic [2:0] K_BEGIN     = 3'd0;
    localparam logic [2:0] K_STATUS    = 3'd1;
    localparam logic [2:0] K_FULLTIME  = 3'd2;
    localparam logic [2:0] K_SETTIME   = 3'd3;
    localparam logic [2:0] K_CFG_START = 3'd4;
    localparam logic [2:0] K_CFG_VALUE = 3'd5;
    localparam logic [2:0] K_DONE      = 3'd6;
    localparam logic [2:0] K_INVALID   = 3'd7;

    typedef struct packed {
        logic        start_of_log;
        logic [15:0] log_word;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       record_kind;
        logic [31:0]      event_time;
        logic [2:0]       status_bits;
        logic [15:0]      item_value;
        logic [15:0]      item_index;
        logic             last_of_block;
        logic [POS_W-1:0] record_position;
    } out_record_t;

    typedef struct packed {
        logic             restart;
        logic             is_mark;
        logic [2:0]       code;
        logic [15:0]      word;
        logic [POS_W-1:0] pos;
    } token_t;

endpackage

// ----- rtl/eld_front.sv -----
module eld_front #(
    parameter int LOG_WORDS = eld_pkg::LOG_WORDS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  eld_pkg::in_word_t in_word,
    output logic             push,
    output eld_pkg::token_t  token,
    input  logic             q_full
);
    import eld_pkg::*;

    localparam logic [16:0] WRAP = 17'(LOG_WORDS);

    logic [POS_W-1:0] wp_reg;
    logic [POS_W-1:0] wp_next;
    logic [POS_W-1:0] pos;
    logic [POS_W:0]   sum;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        pos     = in_word.start_of_log ? '0 : wp_reg;
        sum     = {1'b0, pos} + 1'b1;
        wp_next = (17'(sum) == WRAP) ? '0 : sum[POS_W-1:0];
    end

    always_comb
    begin
        token.restart = in_word.start_of_log;
        token.is_mark = (in_word.log_word[15:3] == OPC_MARK);
        token.code    = in_word.log_word[2:0];
        token.word    = in_word.log_word;
        token.pos     = pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else if (push)
        begin
            wp_reg <= wp_next;
        end
    end

endmodule

// ----- rtl/eld_queue.sv -----
module eld_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  eld_pkg::token_t wr_token,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output eld_pkg::token_t rd_token
);
    import eld_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

    token_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == DEPTH_C);
    assign q_valid  = (count_reg != '0);
    assign rd_token = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count above depth");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == DEPTH_C) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

// ----- rtl/eld_back.sv -----
module eld_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  eld_pkg::token_t     token,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output eld_pkg::out_record_t out_record
);
    import eld_pkg::*;

    localparam logic [2:0] PH_WAIT      = 3'd0;
    localparam logic [2:0] PH_RUN       = 3'd1;
    localparam logic [2:0] PH_FT_LO     = 3'd2;
    localparam logic [2:0] PH_FT_HI     = 3'd3;
    localparam logic [2:0] PH_CFG_COUNT = 3'd4;
    localparam logic [2:0] PH_CFG_VALUE = 3'd5;
    localparam logic [2:0] PH_HALT      = 3'd6;

    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [31:0]      time_reg;
    logic [31:0]      time_next;
    logic [15:0]      hold_reg;
    logic [15:0]      hold_next;
    logic [15:0]      remain_reg;
    logic [15:0]      remain_next;
    logic [15:0]      cpos_reg;
    logic [15:0]      cpos_next;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] start_next;
    logic             out_valid_reg;
    out_record_t      out_reg;

    logic [2:0]       ph;
    logic             emit;
    out_record_t      rec;

    assign pop        = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_record = out_reg;

    always_comb
    begin
        ph          = token.restart ? PH_WAIT : phase_reg;
        phase_next  = ph;
        time_next   = token.restart ? 32'd0 : time_reg;
        hold_next   = hold_reg;
        remain_next = remain_reg;
        cpos_next   = cpos_reg;
        start_next  = start_reg;
        emit        = 1'b0;
        rec         = '0;
        rec.record_position = token.pos;

        unique case (ph)
            PH_WAIT:
            begin
                emit = 1'b1;
                if (token.word == BEGIN_WORD)
                begin
                    rec.record_kind = K_BEGIN;
                    phase_next      = PH_RUN;
                end
                else
                begin
                    time_next       = 32'd0;
                    rec.record_kind = K_INVALID;
                    phase_next      = PH_HALT;
                end
            end
            PH_RUN:
            begin
                if (token.is_mark)
                begin
                    start_next = token.pos;
                    unique case (token.code)
                        OP_FULLTIME: phase_next = PH_FT_LO;
                        OP_CONFIG:   phase_next = PH_CFG_COUNT;
                        OP_SETTIME:
                        begin
                            emit            = 1'b1;
                            rec.record_kind = K_SETTIME;
                        end
                        OP_BEGIN:
                        begin
                            emit            = 1'b1;
                            rec.record_kind = K_BEGIN;
                        end
                        OP_DONE:
                        begin
                            emit            = 1'b1;
                            rec.record_kind = K_DONE;
                            phase_next      = PH_HALT;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    time_next       = time_next + 32'(token.word[15:3]);
                    emit            = 1'b1;
                    rec.record_kind = K_STATUS;
                    rec.status_bits = token.code;
                end
            end
            PH_FT_LO:
            begin
                hold_next  = token.word;
                phase_next = PH_FT_HI;
            end
            PH_FT_HI:
            begin
                time_next           = {token.word, hold_reg};
                emit                = 1'b1;
                rec.record_kind     = K_FULLTIME;
                rec.record_position = start_reg;
                phase_next          = PH_RUN;
            end
            PH_CFG_COUNT:
            begin
                remain_next         = token.word;
                cpos_next           = '0;
                emit                = 1'b1;
                rec.record_kind     = K_CFG_START;
                rec.item_value      = token.word;
                rec.record_position = start_reg;
                phase_next          = (token.word == '0) ? PH_RUN : PH_CFG_VALUE;
            end
            PH_CFG_VALUE:
            begin
                emit                = 1'b1;
                rec.record_kind     = K_CFG_VALUE;
                rec.item_value      = token.word;
                rec.item_index      = cpos_reg;
                rec.last_of_block   = (remain_reg == 16'd1);
                rec.record_position = start_reg;
                cpos_next           = cpos_reg + 1'b1;
                remain_next         = remain_reg - 1'b1;
                if (remain_reg == 16'd1)
                begin
                    phase_next = PH_RUN;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        rec.event_time = time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            time_reg      <= '0;
            hold_reg      <= '0;
            remain_reg    <= '0;
            cpos_reg      <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg  <= phase_next;
                time_reg   <= time_next;
                hold_reg   <= hold_next;
                remain_reg <= remain_next;
                cpos_reg   <= cpos_next;
                start_reg  <= start_next;
            end
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_reg <= rec;
        end
    end

    a_invalid_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.record_kind == K_INVALID |-> out_reg.event_time == '0)
        else $error("invalid record with nonzero time");

    a_last_only_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.record_kind != K_CFG_VALUE |-> !out_reg.last_of_block)
        else $error("last_of_block outside config value");

    a_last_leaves_block: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !token.restart && phase_reg == PH_CFG_VALUE && remain_reg == 16'd1
        |=> phase_reg == PH_RUN)
        else $error("config block did not end on its last value");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled record changed");

endmodule

// ----- rtl/event_log_word_decoder.sv -----
// Decodes a stored event log, one 16-bit word per cycle, into begin, status, time,
// config and done records; a first word other than begin yields one invalid record
// and the decoder then ignores words until start_of_log. A word is accepted every
// cycle while the four-word queue between the word classifier and the record
// sequencer has room; each record is raised on out_valid once its last word
// leaves the queue, held in an output register until taken. Words that open or
// continue a record without ending it give no output. in_ready drops only when the
// output side stalls long enough to fill the queue, so sustained rate is one word
// per cycle without output stalls; the sequencer's time add is combinational.
module event_log_word_decoder #(
    parameter int LOG_WORDS = eld_pkg::LOG_WORDS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  eld_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output eld_pkg::out_record_t out_record
);
    import eld_pkg::*;

    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    token_t wr_token;
    token_t rd_token;

    eld_front #(
        .LOG_WORDS(LOG_WORDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .push     (push),
        .token    (wr_token),
        .q_full   (q_full)
    );

    eld_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_token (wr_token),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .rd_token (rd_token)
    );

    eld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .token      (rd_token),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_record (out_record)
    );

endmodule

// ----- tb/tb.sv -----
module tb;

    import eld_pkg::*;

    localparam int STALL_LIMIT = 500;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [2:0] RESERVED_OPS [3] = '{3'd0, 3'd6, 3'd7};

    typedef enum logic [2:0] {
        DEC_WAIT,
        DEC_RUN,
        DEC_FT_LO,
        DEC_FT_HI,
        DEC_CFG_COUNT,
        DEC_CFG_VALUE,
        DEC_HALT
    } decode_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_record_t out_record;

    decode_phase_t dec_phase = DEC_WAIT;
    logic [31:0]   log_time = '0;
    logic [15:0]   low_half = '0;
    logic [15:0]   cfg_left = '0;
    logic [15:0]   cfg_index = '0;
    logic [11:0]   word_pos = '0;
    logic [11:0]   opcode_pos = '0;

    out_record_t pending_records[$];
    int          mismatches = 0;
    int          live_words = 0;
    int          idle_cycles = 0;
    int          calm_left[2] = '{0, 0};

    event_log_word_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_record (out_record)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [15:0] rand_word();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    function automatic logic [15:0] random_status_word();
        logic [31:0] delta;
        logic [31:0] bits;
        delta = $urandom_range(0, 'h1FFE);
        bits = $urandom_range(0, 7);
        return {delta[12:0], bits[2:0]};
    endfunction

    function automatic string record_text(input out_record_t r);
        return $sformatf("kind=%0d time=%h status=%0d value=%h index=%h last=%0d pos=%h",
                         r.record_kind, r.event_time, r.status_bits, r.item_value,
                         r.item_index, r.last_of_block, r.record_position);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic queue_record(input logic [2:0] kind, input logic [2:0] bits,
                                input logic [15:0] value, input logic [15:0] index,
                                input logic last, input logic [11:0] pos);
        out_record_t r;
        r.record_kind     = kind;
        r.event_time      = log_time;
        r.status_bits     = bits;
        r.item_value      = value;
        r.item_index      = index;
        r.last_of_block   = last;
        r.record_position = pos;
        pending_records.push_back(r);
    endtask

    task automatic decode_word(input in_word_t w);
        logic [15:0] wd;
        logic [11:0] pos;
        wd = w.log_word;
        if (w.start_of_log)
        begin
            dec_phase = DEC_WAIT;
            log_time  = '0;
            word_pos  = '0;
        end
        pos = word_pos;
        case (dec_phase)
            DEC_WAIT:
            begin
                if (wd == BEGIN_WORD)
                begin
                    queue_record(K_BEGIN, '0, '0, '0, 1'b0, pos);
                    dec_phase = DEC_RUN;
                end
                else
                begin
                    log_time = '0;
                    queue_record(K_INVALID, '0, '0, '0, 1'b0, pos);
                    dec_phase = DEC_HALT;
                end
            end
            DEC_RUN:
            begin
                if (wd[15:3] == OPC_MARK)
                begin
                    opcode_pos = pos;
                    case (wd[2:0])
                        OP_FULLTIME: dec_phase = DEC_FT_LO;
                        OP_CONFIG:   dec_phase = DEC_CFG_COUNT;
                        OP_SETTIME:  queue_record(K_SETTIME, '0, '0, '0, 1'b0, pos);
                        OP_BEGIN:    queue_record(K_BEGIN, '0, '0, '0, 1'b0, pos);
                        OP_DONE:
                        begin
                            queue_record(K_DONE, '0, '0, '0, 1'b0, pos);
                            dec_phase = DEC_HALT;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    log_time = log_time + {19'd0, wd[15:3]};
                    queue_record(K_STATUS, wd[2:0], '0, '0, 1'b0, pos);
                end
            end
            DEC_FT_LO:
            begin
                low_half  = wd;
                dec_phase = DEC_FT_HI;
            end
            DEC_FT_HI:
            begin
                log_time = {wd, low_half};
                queue_record(K_FULLTIME, '0, '0, '0, 1'b0, opcode_pos);
                dec_phase = DEC_RUN;
            end
            DEC_CFG_COUNT:
            begin
                cfg_left  = wd;
                cfg_index = '0;
                queue_record(K_CFG_START, '0, wd, '0, 1'b0, opcode_pos);
                dec_phase = (wd == '0) ? DEC_RUN : DEC_CFG_VALUE;
            end
            DEC_CFG_VALUE:
            begin
                queue_record(K_CFG_VALUE, '0, wd, cfg_index, cfg_left == 16'd1, opcode_pos);
                cfg_index = cfg_index + 16'd1;
                cfg_left  = cfg_left - 16'd1;
                if (cfg_left == '0)
                    dec_phase = DEC_RUN;
            end
            default: ;
        endcase
        word_pos = word_pos + 12'd1;
    endtask

    task automatic send_word(input logic start, input logic [15:0] word);
        int       gap;
        in_word_t item;
        gap = draw_wait(0);
        item.start_of_log = start;
        item.log_word     = word;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (start || dec_phase != DEC_HALT)
            live_words++;
        decode_word(item);
    endtask

    task automatic check_record(input out_record_t got);
        out_record_t want;
        if (pending_records.size() == 0)
            note_mismatch($sformatf("record with none expected: %s", record_text(got)));
        else
        begin
            want = pending_records.pop_front();
            if (got.record_kind !== want.record_kind || got.event_time !== want.event_time ||
                got.status_bits !== want.status_bits || got.item_value !== want.item_value ||
                got.item_index !== want.item_index ||
                got.last_of_block !== want.last_of_block ||
                got.record_position !== want.record_position)
                note_mismatch($sformatf("record mismatch: expected %s, got %s",
                                        record_text(want), record_text(got)));
        end
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(1);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            check_record(out_record);
        end
    end

    task automatic send_noise();
        repeat ($urandom_range(0, 3)) send_word(1'b0, rand_word());
    endtask

    task automatic send_log_entry();
        int pick;
        int count;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_word(1'b0, random_status_word());
        else if (pick < 68)
        begin
            send_word(1'b0, {OPC_MARK, OP_FULLTIME});
            send_word(1'b0, rand_word());
            send_word(1'b0, rand_word());
        end
        else if (pick < 73)
            send_word(1'b0, {OPC_MARK, OP_SETTIME});
        else if (pick < 76)
            send_word(1'b0, {OPC_MARK, OP_BEGIN});
        else if (pick < 81)
            send_word(1'b0, {OPC_MARK, RESERVED_OPS[$urandom_range(0, 2)]});
        else
        begin
            count = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            send_word(1'b0, {OPC_MARK, OP_CONFIG});
            send_word(1'b0, count[15:0]);
            repeat (count) send_word(1'b0, rand_word());
        end
    endtask

    task automatic send_log(input int entries, input bit finish);
        send_word(1'b1, BEGIN_WORD);
        repeat (entries) send_log_entry();
        if (finish)
            send_word(1'b0, {OPC_MARK, OP_DONE});
    endtask

    // cut a log short, or open one with a non-begin word; the next start_of_log ends it
    task automatic send_broken_log();
        logic [15:0] first;
        logic [31:0] count;
        case ($urandom_range(0, 3))
            0:
            begin
                first = rand_word();
                if (first == BEGIN_WORD)
                    first = '0;
                send_word(1'b1, first);
                send_noise();
            end
            1:
            begin
                send_log($urandom_range(0, 6), 1'b0);
                send_word(1'b0, {OPC_MARK, OP_FULLTIME});
                if ($urandom_range(0, 1) == 1)
                    send_word(1'b0, rand_word());
            end
            2:
            begin
                send_log($urandom_range(0, 6), 1'b0);
                count = $urandom_range(6, 65535);
                send_word(1'b0, {OPC_MARK, OP_CONFIG});
                send_word(1'b0, count[15:0]);
                repeat ($urandom_range(0, 5)) send_word(1'b0, rand_word());
            end
            default: send_log($urandom_range(1, 20), 1'b0);
        endcase
    endtask

    task automatic test_wait_without_start();
        send_word(1'b0, BEGIN_WORD);
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'hFFF7);
        send_word(1'b0, {OPC_MARK, OP_DONE});
        send_word(1'b0, 16'h5A5A);
    endtask

    task automatic test_invalid_first_word();
        send_word(1'b1, 16'h0000);
        send_word(1'b0, BEGIN_WORD);
        send_word(1'b1, 16'hFFFF);
    endtask

    task automatic test_opcodes();
        send_word(1'b1, BEGIN_WORD);
        send_word(1'b0, {OPC_MARK, OP_SETTIME});
        send_word(1'b0, {OPC_MARK, OP_BEGIN});
        send_word(1'b0, {OPC_MARK, RESERVED_OPS[0]});
        send_word(1'b0, {OPC_MARK, RESERVED_OPS[1]});
        send_word(1'b0, {OPC_MARK, RESERVED_OPS[2]});
        send_word(1'b0, {OPC_MARK, OP_FULLTIME});
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'h0008);
    endtask

    task automatic test_config_blocks();
        send_word(1'b0, {OPC_MARK, OP_CONFIG});
        send_word(1'b0, 16'h0000);
        send_word(1'b0, {OPC_MARK, OP_CONFIG});
        send_word(1'b0, 16'h0002);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'h0000);
        send_word(1'b0, {OPC_MARK, OP_DONE});
    endtask

    task automatic test_random_logs();
        int target;
        target = 1550;
        while (live_words < target)
        begin
            if ($urandom_range(0, 4) == 0)
                send_broken_log();
            else
            begin
                send_log($urandom_range(0, 40), 1'b1);
                send_noise();
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_wait_without_start();
        test_invalid_first_word();
        test_opcodes();
        test_config_blocks();
        test_random_logs();
        in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_records.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/eld_pkg.sv
rtl/eld_front.sv
rtl/eld_queue.sv
rtl/eld_back.sv
rtl/event_log_word_decoder.sv
tb/tb.sv
